// ===== design/multi_queue_circular_fifo_top_macros.svh =====
// assertion helpers for the multi-queue fifo
`ifndef MULTI_QUEUE_CIRCULAR_FIFO_TOP_MACROS_SVH
`define MULTI_QUEUE_CIRCULAR_FIFO_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define MQCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MQCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mqcf_pkg.sv =====
package mqcf_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 8;

  localparam int QIDX_W  = 3;
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W  = QIDX_W + SLOT_W;
  localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ID_W    = 16;
  localparam int FILL_W  = 4;
  localparam int CFG_W   = 4;
  localparam int CIDX_W  = 2;
  localparam int STAT_W  = 2;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED   = 2'd0,
    ST_REJECTED = 2'd1,
    ST_POPPED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [CIDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ACTIVE   = 2'd1;

endpackage

// ===== design/multi_queue_circular_fifo_top.sv =====
// timing: the result beat of an accepted input beat is registered and appears in the following cycle
// throughput: one beat per cycle while out_ready is high; the single result
//   register back-pressures the input when a result is held
// reset (rst_n low, synchronous): all queues empty, heads zero, capacity 7,
//   active queues 5, no result pending; stored identifiers are not cleared
module multi_queue_circular_fifo_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [mqcf_pkg::QIDX_W-1:0]  in_queue_index,
  input  logic [mqcf_pkg::ID_W-1:0]    in_item_id,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mqcf_pkg::STAT_W-1:0]  out_status,
  output logic [mqcf_pkg::ID_W-1:0]    out_popped_id,
  output logic [mqcf_pkg::FILL_W-1:0]  out_queue_fill,
  output logic                         out_all_full,
  // register write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mqcf_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [mqcf_pkg::CFG_W-1:0]   cfg_data
);

  import mqcf_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] cap_r;
  logic [CFG_W-1:0] active_r;

  // per-queue bookkeeping, kept in flops
  logic [SLOT_W-1:0] head_r [NUM_QUEUES];
  logic [FILL_W-1:0] fill_r [NUM_QUEUES];
  logic [SLOT_W-1:0] head_nxt [NUM_QUEUES];
  logic [FILL_W-1:0] fill_nxt [NUM_QUEUES];

  // identifier storage, one row of QUEUE_DEPTH slots per queue
  logic [ID_W-1:0] mem [ENTRIES];
  logic [ID_W-1:0] rd_data_r;

  // result register
  logic              out_valid_r;
  status_t           status_r;
  logic [FILL_W-1:0] fill_out_r;
  logic              all_full_r;

  logic              in_acc;
  logic [FILL_W-1:0] cap_eff;
  logic [CFG_W-1:0]  active_eff;
  logic [FILL_W-1:0] q_fill;
  logic [SLOT_W-1:0] q_head;
  logic              q_full;
  logic              q_empty;
  logic              push_ok;
  logic              pop_ok;
  logic [SLOT_W-1:0] wr_slot;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  status_t           status_nxt;
  logic              all_full_nxt;

  // the result register empties when taken, so a new beat may enter
  // in the same cycle the old result leaves
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // register writes, out-of-list indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CFG_W'(7);
      active_r <= CFG_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CAPACITY: cap_r    <= cfg_data;
        REG_ACTIVE:   active_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // clamp capacity to 1..QUEUE_DEPTH and active count to NUM_QUEUES
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = FILL_W'(1);
    end else if (FILL_W'(cap_r) > FILL_W'(QUEUE_DEPTH)) begin
      cap_eff = FILL_W'(QUEUE_DEPTH);
    end else begin
      cap_eff = FILL_W'(cap_r);
    end
    if (active_r > CFG_W'(NUM_QUEUES)) begin
      active_eff = CFG_W'(NUM_QUEUES);
    end else begin
      active_eff = active_r;
    end
  end

  // addressed queue lookup
  assign q_fill  = fill_r[in_queue_index];
  assign q_head  = head_r[in_queue_index];
  assign q_full  = (q_fill >= cap_eff);
  assign q_empty = (q_fill == '0);
  assign push_ok = (in_command == CMD_PUSH) && !q_full;
  assign pop_ok  = (in_command == CMD_POP) && !q_empty;

  // tail slot wraps at the row length
  assign wr_slot = SLOT_W'(q_head + q_fill[SLOT_W-1:0]);
  assign wr_addr = {in_queue_index, wr_slot};
  assign rd_addr = {in_queue_index, q_head};

  always_comb begin
    if (in_command == CMD_PUSH) begin
      status_nxt = q_full ? ST_REJECTED : ST_PUSHED;
    end else begin
      status_nxt = q_empty ? ST_EMPTY : ST_POPPED;
    end
  end

  // next head and fill per queue; only the addressed one moves
  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      head_nxt[i] = head_r[i];
      fill_nxt[i] = fill_r[i];
      if (in_acc && (in_queue_index == QIDX_W'(i))) begin
        if (push_ok) begin
          fill_nxt[i] = fill_r[i] + FILL_W'(1);
        end else if (pop_ok) begin
          fill_nxt[i] = fill_r[i] - FILL_W'(1);
          head_nxt[i] = SLOT_W'(head_r[i] + SLOT_W'(1));
        end
      end
    end
  end

  // all-full flag judged on the post-operation fills
  always_comb begin
    all_full_nxt = 1'b1;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if ((CFG_W'(i) < active_eff) && (fill_nxt[i] < cap_eff)) begin
        all_full_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= head_nxt[i];
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

  // storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_acc && push_ok) begin
      mem[wr_addr] <= in_item_id;
    end
    if (in_acc && pop_ok) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r   <= status_nxt;
      fill_out_r <= fill_nxt[in_queue_index];
      all_full_r <= all_full_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_popped_id  = (status_r == ST_POPPED) ? rd_data_r : '0;
  assign out_queue_fill = fill_out_r;
  assign out_all_full   = all_full_r;

  `include "multi_queue_circular_fifo_top_macros.svh"

  // a held result must block new commands
  `MQCF_ASSERT_NOW(a_stall_blocks_in, out_valid_r && !out_ready, !in_ready, "input taken while result held")

  // every accepted command yields a result next cycle
  `MQCF_ASSERT_NEXT(a_acc_gives_result, in_acc, out_valid_r, "accepted command produced no result")

  // a successful push leaves at least one entry
  `MQCF_ASSERT_NOW(a_push_nonempty, out_valid_r && status_r == ST_PUSHED, fill_out_r != '0, "push reported with empty queue")

  // empty pop reports an empty queue and a zero identifier
  `MQCF_ASSERT_NOW(a_empty_pop, out_valid_r && status_r == ST_EMPTY, fill_out_r == '0 && out_popped_id == '0, "bad empty-pop result")

endmodule
